### design/gpm_pkg.sv
// Glob matcher package: shared types, character codes and byte helpers.
// No dependencies; used by the controller, datapath and top level of the glob matcher.
`default_nettype none

package gpm_pkg;

    // mode field codes
    localparam logic [1:0] MODE_PAT  = 2'd0;
    localparam logic [1:0] MODE_SUBJ = 2'd1;
    localparam logic [1:0] MODE_RUN  = 2'd2;

    // match_flags bit positions
    localparam int FLAG_NOESC  = 0;
    localparam int FLAG_PATH   = 1;
    localparam int FLAG_PERIOD = 2;
    localparam int FLAG_FOLD   = 3;

    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef enum logic [4:0] {
        S_IDLE, S_FETCH, S_DECIDE, S_LIT_F, S_LIT, S_STAR_F, S_STAR,
        S_SCAN_F, S_SCAN, S_MISS_F, S_MISS, S_BNEG_F, S_BNEG, S_BRB_F, S_BRB,
        S_BLOOP_F, S_BLOOP, S_BFIRST_F, S_BFIRST, S_BDASH_F, S_BDASH,
        S_BPEEK_F, S_BPEEK, S_BLAST_F, S_BLAST, S_EMIT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_START, OP_STEP, OP_PI_INC, OP_SET_RETRY,
        OP_SI_INC, OP_RETRY, OP_BR_INIT, OP_BR_NEG, OP_BR_RB, OP_N_INC,
        OP_N_INC2, OP_BR_FIRST, OP_BR_SINGLE, OP_BR_RANGE1, OP_BR_RANGE,
        OP_BR_DONE, OP_EMIT
    } t_op;

    typedef enum logic [1:0] {PS_PI, PS_N, PS_N1} t_psel;
    typedef enum logic {SS_SI, SS_RS} t_ssel;

    typedef struct packed {
        t_op   op;
        t_psel psel;
        t_ssel ssel;
        logic  matched;
    } t_cmd;

    typedef struct packed {
        logic pend;       // pattern index at end
        logic send;       // subject index at end
        logic n_lt;       // bracket index inside pattern
        logic n1_lt;
        logic n2_lt;
        logic pi1_lt;
        logic rs_lt;
        logic pd_quest;
        logic pd_star;
        logic pd_lbrk;
        logic pd_rbrk;
        logic pd_bsl;
        logic pd_neg;
        logic pd_dash;
        logic s_sep;
        logic s_dot;
        logic lit_eq;
        logic have_retry;
        logic hit_ne_neg;
        logic seg;
        logic ovf;
        logic esc;
        logic path;
        logic period;
        logic out_free;
    } t_status;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
        logic [7:0] r;
        r = b;
        if (en && b >= CH_UP_A && b <= CH_UP_Z) begin
            r = b + CASE_OFS;
        end
        return r;
    endfunction

    function automatic logic is_sep(input logic [7:0] b);
        return (b == CH_SLASH) || (b == CH_BSL);
    endfunction

endpackage

`default_nettype wire

### design/gpm_datapath.sv
// Glob matcher datapath: pattern and subject stores, indexes, bracket state,
// result register. Depends on gpm_pkg; driven by gpm_ctrl commands.
`default_nettype none

module gpm_datapath #(
    parameter int PATTERN_DEPTH = 64,
    parameter int SUBJECT_DEPTH = 256
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire gpm_pkg::t_cmd   i_cmd,
    input  wire logic [1:0]      i_mode,
    input  wire logic [7:0]      i_char_byte,
    input  wire logic [3:0]      i_flags,
    input  wire logic            i_out_stall,
    output gpm_pkg::t_status     o_status,
    output logic                 o_out_valid,
    output logic                 o_matched,
    output logic                 o_overflow
);

    localparam int PAW = $clog2(PATTERN_DEPTH);
    localparam int PW  = $clog2(PATTERN_DEPTH + 1);
    localparam int SAW = $clog2(SUBJECT_DEPTH);
    localparam int SW  = $clog2(SUBJECT_DEPTH + 1);

    logic [7:0] r_pmem [PATTERN_DEPTH];
    logic [7:0] r_smem [SUBJECT_DEPTH];

    logic [PW-1:0] r_plen, r_pi, r_rp, r_bpos;
    logic [SW-1:0] r_slen, r_si, r_rs;
    logic          r_ovf, r_seg, r_hr, r_neg, r_hit, r_sep;
    logic [7:0]    r_first, r_ch, r_pd, r_sd;
    logic          r_ovalid, r_omatched, r_oover;

    logic [PW-1:0] w_pidx;
    logic [SW-1:0] w_sidx;
    logic          w_fold, w_esc, w_pwr, w_swr;
    logic [7:0]    w_fpd;
    logic [PW:0]   w_bpos1, w_bpos2, w_pi1;

    assign w_fold = i_flags[gpm_pkg::FLAG_FOLD];
    assign w_esc  = !i_flags[gpm_pkg::FLAG_NOESC];
    assign w_fpd  = gpm_pkg::fold_byte(r_pd, w_fold);

    always_comb begin
        case (i_cmd.psel)
            gpm_pkg::PS_N:  w_pidx = r_bpos;
            gpm_pkg::PS_N1: w_pidx = r_bpos + PW'(1);
            default:        w_pidx = r_pi;
        endcase
        w_sidx = (i_cmd.ssel == gpm_pkg::SS_RS) ? r_rs : r_si;
    end

    assign w_pwr = (i_cmd.op == gpm_pkg::OP_LOAD) && (i_mode == gpm_pkg::MODE_PAT) &&
                   (r_plen < PW'(PATTERN_DEPTH));
    assign w_swr = (i_cmd.op == gpm_pkg::OP_LOAD) && (i_mode == gpm_pkg::MODE_SUBJ) &&
                   (r_slen < SW'(SUBJECT_DEPTH));

    // stores: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (w_pwr) begin
            r_pmem[r_plen[PAW-1:0]] <= i_char_byte;
        end
        r_pd <= r_pmem[w_pidx[PAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_swr) begin
            r_smem[r_slen[SAW-1:0]] <= i_char_byte;
        end
        r_sd <= r_smem[w_sidx[SAW-1:0]];
    end

    assign w_bpos1 = {1'b0, r_bpos} + (PW + 1)'(1);
    assign w_bpos2 = {1'b0, r_bpos} + (PW + 1)'(2);
    assign w_pi1   = {1'b0, r_pi} + (PW + 1)'(1);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen   <= '0;
            r_slen   <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            case (i_cmd.op)
                gpm_pkg::OP_LOAD: begin
                    if (w_pwr) begin
                        r_plen <= r_plen + PW'(1);
                    end else if (w_swr) begin
                        r_slen <= r_slen + SW'(1);
                    end else if (i_mode == gpm_pkg::MODE_PAT ||
                                 i_mode == gpm_pkg::MODE_SUBJ) begin
                        r_ovf <= 1'b1;
                    end
                end
                gpm_pkg::OP_EMIT: begin
                    r_ovalid <= 1'b1;
                    r_plen   <= '0;
                    r_slen   <= '0;
                    r_ovf    <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            gpm_pkg::OP_START: begin
                r_pi  <= '0;
                r_si  <= '0;
                r_hr  <= 1'b0;
                r_seg <= 1'b1;
            end
            gpm_pkg::OP_STEP: begin
                r_pi  <= r_pi + PW'(1);
                r_si  <= r_si + SW'(1);
                r_seg <= gpm_pkg::is_sep(r_sd);
            end
            gpm_pkg::OP_PI_INC: r_pi <= r_pi + PW'(1);
            gpm_pkg::OP_SET_RETRY: begin
                r_hr <= 1'b1;
                r_rp <= r_pi;
                r_rs <= r_si;
            end
            gpm_pkg::OP_SI_INC: r_si <= r_si + SW'(1);
            gpm_pkg::OP_RETRY: begin
                r_seg <= gpm_pkg::is_sep(r_sd);
                r_rs  <= r_rs + SW'(1);
                r_si  <= r_rs + SW'(1);
                r_pi  <= r_rp;
            end
            gpm_pkg::OP_BR_INIT: begin
                r_bpos <= r_pi + PW'(1);
                r_ch   <= gpm_pkg::fold_byte(r_sd, w_fold);
                r_sep  <= gpm_pkg::is_sep(r_sd);
                r_neg  <= 1'b0;
                r_hit  <= 1'b0;
            end
            gpm_pkg::OP_BR_NEG: begin
                r_neg  <= 1'b1;
                r_bpos <= r_bpos + PW'(1);
            end
            gpm_pkg::OP_BR_RB: begin
                if (r_ch == gpm_pkg::CH_RBRK) begin
                    r_hit <= 1'b1;
                end
                r_bpos <= r_bpos + PW'(1);
            end
            gpm_pkg::OP_N_INC:  r_bpos <= r_bpos + PW'(1);
            gpm_pkg::OP_N_INC2: r_bpos <= r_bpos + PW'(2);
            gpm_pkg::OP_BR_FIRST: begin
                r_first <= w_fpd;
                r_bpos  <= r_bpos + PW'(1);
            end
            gpm_pkg::OP_BR_SINGLE: begin
                if (r_first == r_ch) begin
                    r_hit <= 1'b1;
                end
            end
            gpm_pkg::OP_BR_RANGE1: begin
                if (r_first <= r_ch && r_ch <= w_fpd) begin
                    r_hit <= 1'b1;
                end
                r_bpos <= r_bpos + PW'(2);
            end
            gpm_pkg::OP_BR_RANGE: begin
                if (r_first <= r_ch && r_ch <= w_fpd) begin
                    r_hit <= 1'b1;
                end
                r_bpos <= r_bpos + PW'(1);
            end
            gpm_pkg::OP_BR_DONE: begin
                r_pi  <= r_bpos + PW'(1);
                r_si  <= r_si + SW'(1);
                r_seg <= r_sep;
            end
            gpm_pkg::OP_EMIT: begin
                r_omatched <= i_cmd.matched;
                r_oover    <= r_ovf;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_status.pend       = r_pi >= r_plen;
        o_status.send       = r_si >= r_slen;
        o_status.n_lt       = r_bpos < r_plen;
        o_status.n1_lt      = w_bpos1 < {1'b0, r_plen};
        o_status.n2_lt      = w_bpos2 < {1'b0, r_plen};
        o_status.pi1_lt     = w_pi1 < {1'b0, r_plen};
        o_status.rs_lt      = r_rs < r_slen;
        o_status.pd_quest   = r_pd == gpm_pkg::CH_QUEST;
        o_status.pd_star    = r_pd == gpm_pkg::CH_STAR;
        o_status.pd_lbrk    = r_pd == gpm_pkg::CH_LBRK;
        o_status.pd_rbrk    = r_pd == gpm_pkg::CH_RBRK;
        o_status.pd_bsl     = r_pd == gpm_pkg::CH_BSL;
        o_status.pd_neg     = (r_pd == gpm_pkg::CH_BANG) || (r_pd == gpm_pkg::CH_CARET);
        o_status.pd_dash    = r_pd == gpm_pkg::CH_DASH;
        o_status.s_sep      = gpm_pkg::is_sep(r_sd);
        o_status.s_dot      = r_sd == gpm_pkg::CH_DOT;
        o_status.lit_eq     = w_fpd == gpm_pkg::fold_byte(r_sd, w_fold);
        o_status.have_retry = r_hr;
        o_status.hit_ne_neg = r_hit != r_neg;
        o_status.seg        = r_seg;
        o_status.ovf        = r_ovf;
        o_status.esc        = w_esc;
        o_status.path       = i_flags[gpm_pkg::FLAG_PATH];
        o_status.period     = i_flags[gpm_pkg::FLAG_PERIOD];
        o_status.out_free   = !r_ovalid || !i_out_stall;
    end

    assign o_out_valid = r_ovalid;
    assign o_matched   = r_omatched;
    assign o_overflow  = r_oover;

endmodule

`default_nettype wire

### design/gpm_ctrl.sv
// Glob matcher controller: state machine sequencing the match walk.
// Depends on gpm_pkg; commands gpm_datapath and reads its status.
`default_nettype none

module gpm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [1:0]        i_mode,
    input  wire gpm_pkg::t_status  i_status,
    output logic                   o_in_stall,
    output gpm_pkg::t_cmd          o_cmd
);

    gpm_pkg::t_state r_state, n_state;
    logic            r_result, n_result;
    logic            w_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gpm_pkg::S_IDLE;
            r_result <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_result <= n_result;
        end
    end

    // single-byte wildcard allowed on current subject byte
    assign w_ok = !i_status.send && !(i_status.path && i_status.s_sep) &&
                  !(i_status.period && i_status.seg && i_status.s_dot);

    always_comb begin
        n_state       = r_state;
        n_result      = r_result;
        o_cmd.op      = gpm_pkg::OP_NONE;
        o_cmd.psel    = gpm_pkg::PS_PI;
        o_cmd.ssel    = gpm_pkg::SS_SI;
        o_cmd.matched = r_result;
        o_in_stall    = (r_state != gpm_pkg::S_IDLE);
        case (r_state)
            gpm_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_mode == gpm_pkg::MODE_PAT || i_mode == gpm_pkg::MODE_SUBJ) begin
                        o_cmd.op = gpm_pkg::OP_LOAD;
                    end else if (i_mode == gpm_pkg::MODE_RUN) begin
                        if (i_status.ovf) begin
                            n_result = 1'b0;
                            n_state  = gpm_pkg::S_EMIT;
                        end else begin
                            o_cmd.op = gpm_pkg::OP_START;
                            n_state  = gpm_pkg::S_FETCH;
                        end
                    end
                end
            end
            gpm_pkg::S_FETCH: n_state = gpm_pkg::S_DECIDE;
            gpm_pkg::S_DECIDE: begin
                if (i_status.pend) begin
                    if (i_status.send) begin
                        n_result = 1'b1;
                        n_state  = gpm_pkg::S_EMIT;
                    end else begin
                        n_state = gpm_pkg::S_MISS_F;
                    end
                end else if (i_status.pd_quest) begin
                    if (w_ok) begin
                        o_cmd.op = gpm_pkg::OP_STEP;
                        n_state  = gpm_pkg::S_FETCH;
                    end else begin
                        n_state = gpm_pkg::S_MISS_F;
                    end
                end else if (i_status.pd_star) begin
                    o_cmd.op = gpm_pkg::OP_PI_INC;
                    n_state  = gpm_pkg::S_STAR_F;
                end else if (i_status.pd_lbrk) begin
                    if (w_ok) begin
                        o_cmd.op = gpm_pkg::OP_BR_INIT;
                        n_state  = gpm_pkg::S_BNEG_F;
                    end else begin
                        n_state = gpm_pkg::S_MISS_F;
                    end
                end else if (i_status.pd_bsl && i_status.esc && i_status.pi1_lt) begin
                    o_cmd.op = gpm_pkg::OP_PI_INC;
                    n_state  = gpm_pkg::S_LIT_F;
                end else if (!i_status.send && i_status.lit_eq) begin
                    o_cmd.op = gpm_pkg::OP_STEP;
                    n_state  = gpm_pkg::S_FETCH;
                end else begin
                    n_state = gpm_pkg::S_MISS_F;
                end
            end
            gpm_pkg::S_LIT_F: n_state = gpm_pkg::S_LIT;
            gpm_pkg::S_LIT: begin
                if (!i_status.send && i_status.lit_eq) begin
                    o_cmd.op = gpm_pkg::OP_STEP;
                    n_state  = gpm_pkg::S_FETCH;
                end else begin
                    n_state = gpm_pkg::S_MISS_F;
                end
            end
            gpm_pkg::S_STAR_F: n_state = gpm_pkg::S_STAR;
            gpm_pkg::S_STAR: begin
                if (!i_status.pend && i_status.pd_star) begin
                    o_cmd.op = gpm_pkg::OP_PI_INC;
                    n_state  = gpm_pkg::S_STAR_F;
                end else if (i_status.period && i_status.seg && !i_status.send &&
                             i_status.s_dot) begin
                    n_state = gpm_pkg::S_MISS_F;
                end else if (i_status.pend) begin
                    if (i_status.path) begin
                        n_state = gpm_pkg::S_SCAN_F;
                    end else begin
                        n_result = 1'b1;
                        n_state  = gpm_pkg::S_EMIT;
                    end
                end else begin
                    o_cmd.op = gpm_pkg::OP_SET_RETRY;
                    n_state  = gpm_pkg::S_FETCH;
                end
            end
            gpm_pkg::S_SCAN_F: begin
                if (i_status.send) begin
                    n_result = 1'b1;
                    n_state  = gpm_pkg::S_EMIT;
                end else begin
                    n_state = gpm_pkg::S_SCAN;
                end
            end
            gpm_pkg::S_SCAN: begin
                if (i_status.s_sep) begin
                    n_state = gpm_pkg::S_MISS_F;
                end else begin
                    o_cmd.op = gpm_pkg::OP_SI_INC;
                    n_state  = gpm_pkg::S_SCAN_F;
                end
            end
            gpm_pkg::S_MISS_F: begin
                o_cmd.ssel = gpm_pkg::SS_RS;
                if (!i_status.have_retry || !i_status.rs_lt) begin
                    n_result = 1'b0;
                    n_state  = gpm_pkg::S_EMIT;
                end else begin
                    n_state = gpm_pkg::S_MISS;
                end
            end
            gpm_pkg::S_MISS: begin
                if (i_status.path && i_status.s_sep) begin
                    n_result = 1'b0;
                    n_state  = gpm_pkg::S_EMIT;
                end else begin
                    o_cmd.op = gpm_pkg::OP_RETRY;
                    n_state  = gpm_pkg::S_FETCH;
                end
            end
            gpm_pkg::S_BNEG_F: begin
                o_cmd.psel = gpm_pkg::PS_N;
                n_state    = gpm_pkg::S_BNEG;
            end
            gpm_pkg::S_BNEG: begin
                if (i_status.n_lt && i_status.pd_neg) begin
                    o_cmd.op = gpm_pkg::OP_BR_NEG;
                end
                n_state = gpm_pkg::S_BRB_F;
            end
            gpm_pkg::S_BRB_F: begin
                o_cmd.psel = gpm_pkg::PS_N;
                n_state    = gpm_pkg::S_BRB;
            end
            gpm_pkg::S_BRB: begin
                if (i_status.n_lt && i_status.pd_rbrk) begin
                    o_cmd.op = gpm_pkg::OP_BR_RB;
                end
                n_state = gpm_pkg::S_BLOOP_F;
            end
            gpm_pkg::S_BLOOP_F: begin
                o_cmd.psel = gpm_pkg::PS_N;
                n_state    = gpm_pkg::S_BLOOP;
            end
            gpm_pkg::S_BLOOP: begin
                if (!i_status.n_lt) begin
                    n_state = gpm_pkg::S_MISS_F;       // unclosed bracket
                end else if (i_status.pd_rbrk) begin
                    if (i_status.hit_ne_neg) begin
                        o_cmd.op = gpm_pkg::OP_BR_DONE;
                        n_state  = gpm_pkg::S_FETCH;
                    end else begin
                        n_state = gpm_pkg::S_MISS_F;
                    end
                end else if (i_status.pd_bsl && i_status.esc && i_status.n1_lt) begin
                    o_cmd.op = gpm_pkg::OP_N_INC;
                    n_state  = gpm_pkg::S_BFIRST_F;
                end else begin
                    o_cmd.op = gpm_pkg::OP_BR_FIRST;
                    n_state  = gpm_pkg::S_BDASH_F;
                end
            end
            gpm_pkg::S_BFIRST_F: begin
                o_cmd.psel = gpm_pkg::PS_N;
                n_state    = gpm_pkg::S_BFIRST;
            end
            gpm_pkg::S_BFIRST: begin
                o_cmd.op = gpm_pkg::OP_BR_FIRST;
                n_state  = gpm_pkg::S_BDASH_F;
            end
            gpm_pkg::S_BDASH_F: begin
                o_cmd.psel = gpm_pkg::PS_N;
                n_state    = gpm_pkg::S_BDASH;
            end
            gpm_pkg::S_BDASH: begin
                if (i_status.n_lt && i_status.pd_dash && i_status.n1_lt) begin
                    n_state = gpm_pkg::S_BPEEK_F;
                end else begin
                    o_cmd.op = gpm_pkg::OP_BR_SINGLE;
                    n_state  = gpm_pkg::S_BLOOP_F;
                end
            end
            gpm_pkg::S_BPEEK_F: begin
                o_cmd.psel = gpm_pkg::PS_N1;
                n_state    = gpm_pkg::S_BPEEK;
            end
            gpm_pkg::S_BPEEK: begin
                if (i_status.pd_rbrk) begin
                    o_cmd.op = gpm_pkg::OP_BR_SINGLE;   // dash before ] is literal
                    n_state  = gpm_pkg::S_BLOOP_F;
                end else if (i_status.pd_bsl && i_status.esc && i_status.n2_lt) begin
                    o_cmd.op = gpm_pkg::OP_N_INC2;
                    n_state  = gpm_pkg::S_BLAST_F;
                end else begin
                    o_cmd.op = gpm_pkg::OP_BR_RANGE1;
                    n_state  = gpm_pkg::S_BLOOP_F;
                end
            end
            gpm_pkg::S_BLAST_F: begin
                o_cmd.psel = gpm_pkg::PS_N;
                n_state    = gpm_pkg::S_BLAST;
            end
            gpm_pkg::S_BLAST: begin
                o_cmd.op = gpm_pkg::OP_BR_RANGE;
                n_state  = gpm_pkg::S_BLOOP_F;
            end
            gpm_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.op = gpm_pkg::OP_EMIT;
                    n_state  = gpm_pkg::S_IDLE;
                end
            end
            default: n_state = gpm_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

### design/glob_pattern_matcher_core.sv
// Glob matcher top level: flags register, controller and datapath.
// Depends on gpm_pkg, gpm_ctrl and gpm_datapath.
`default_nettype none

// Loads a glob pattern and a subject one byte per input word (mode 0 and
// mode 1) and on a run word (mode 2) returns one result word: matched and
// overflow. Supports ?, *, bracket sets with ! or ^ negation, ranges and a
// leading ], backslash escapes, and the flags no-escape, pathname,
// leading-period and ASCII case fold (match_flags; the user must write
// them on the cfg channel only while idle, the block does not enforce
// it). Only the most recent * is retried. A run walks the pattern step by
// step: each step is one store read with registered data and then one
// decision, and an escaped literal takes a second read; a bracket first
// does its set up (negation and leading ] checks), then reads each set
// element (a range and each escape inside need further reads) and then
// the closing ]; a star retry restarts the walk one subject byte later,
// and a trailing star in pathname mode scans the rest of the subject one
// byte at a time. Each store has a single read port, which is why each
// step waits for the registered read. The input is stalled while a run is
// in progress; the result sits in an output register, so loads for the
// next run are taken while it waits. Both stores are emptied by a run; no
// clearing pass is needed after reset.
module glob_pattern_matcher_core #(
    parameter int PATTERN_DEPTH = 64,
    parameter int SUBJECT_DEPTH = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_mode,
    input  wire logic [7:0] i_char_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_matched,
    output logic            o_overflow,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [3:0] i_cfg_data
);

    logic [3:0]       r_flags;
    gpm_pkg::t_cmd    w_cmd;
    gpm_pkg::t_status w_status;

    // match_flags register; always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_cfg_valid) begin
            r_flags <= i_cfg_data;
        end
    end

    gpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    gpm_datapath #(
        .PATTERN_DEPTH (PATTERN_DEPTH),
        .SUBJECT_DEPTH (SUBJECT_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_mode      (i_mode),
        .i_char_byte (i_char_byte),
        .i_flags     (r_flags),
        .i_out_stall (i_out_stall),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_matched   (o_matched),
        .o_overflow  (o_overflow)
    );

endmodule

`default_nettype wire

### design/gpm_checker.sv
// Port-level checker for the glob matcher, bound to the top level.
// Depends only on glob_pattern_matcher_core's ports.
`default_nettype none

module gpm_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_in_stall,
    input wire logic o_out_valid,
    input wire logic i_out_stall,
    input wire logic o_matched,
    input wire logic o_overflow
);

    // result word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_matched) &&
        $stable(o_overflow))
        else $error("result word changed while stalled");

    // an overflowed run never reports a match
    a_ovf_nomatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> !o_matched)
        else $error("match reported with overflow");

    // reset leaves the block idle with no result
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("not idle after reset");

    // a new result follows a run in progress
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without run");

endmodule

bind glob_pattern_matcher_core gpm_checker u_gpm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_matched   (o_matched),
    .o_overflow  (o_overflow)
);

`default_nettype wire
